/* rtl/core/modular_number_theory_unit_defines.svh */
// ----------------------------------------------------------------------------
// Modular number theory unit assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_NUMBER_THEORY_UNIT_DEFINES_SVH
`define MODULAR_NUMBER_THEORY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MNTU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MNTU_ASSERT_NEXT(name, ante, cons, msg) \
  `MNTU_ASSERT(name, (ante) |=> (cons), msg)
`else
`define MNTU_ASSERT(name, prop, msg)
`define MNTU_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* rtl/core/mntu_pkg.sv */
// ----------------------------------------------------------------------------
// Modular number theory unit package
// Shared widths, function codes, transaction types, commands and states.
// ----------------------------------------------------------------------------
package mntu_pkg;

  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned OPW       = 32;
  localparam int unsigned DW        = 64;
  localparam int unsigned EW        = 8;
  localparam int unsigned COEF_W    = 34;

  localparam logic [2:0] FUNC_GCD   = 3'd0;
  localparam logic [2:0] FUNC_POW   = 3'd1;
  localparam logic [2:0] FUNC_INV   = 3'd2;
  localparam logic [2:0] FUNC_PRIME = 3'd3;
  localparam logic [2:0] FUNC_RSA   = 3'd4;

  localparam logic [EW-1:0] E_FIRST = 8'd2;
  localparam logic [EW-1:0] E_LIMIT = 8'd255;
  localparam logic [1:0]    BASE_LAST = 2'd2;

  typedef struct packed {
    logic [2:0]     func;
    logic [OPW-1:0] operand_a;
    logic [OPW-1:0] operand_b;
    logic [OPW-1:0] modulus_in;
  } req_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic [EW-1:0] public_exp;
    logic [DW-1:0] private_exp;
    logic          found;
    logic          error;
  } rsp_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_ERR, CMD_SET_ONE, CMD_FOUND,
    CMD_DIV_AB, CMD_GCD_STEP, CMD_GCD_DONE,
    CMD_PW_INIT, CMD_DIV_BASE, CMD_SET_BASE, CMD_MUL_RB, CMD_DIV_PROD, CMD_SET_R,
    CMD_MUL_BB, CMD_SET_BASE_SHIFT, CMD_PW_DONE, CMD_BI_INC,
    CMD_INV_INIT, CMD_MUL_QS, CMD_INV_STEP, CMD_INV_DONE,
    CMD_RSA_MUL_N, CMD_RSA_MUL_PHI, CMD_RSA_GCD_INIT, CMD_E_INC, CMD_DIV_PHI,
    CMD_K_INIT, CMD_K_STEP, CMD_K_HIT, CMD_RSA_DONE, CMD_PUBLISH
  } cmd_e;

  typedef enum logic [26:0] {
    S_IDLE        = 27'h0000001,
    S_DISPATCH    = 27'h0000002,
    S_ERR         = 27'h0000004,
    S_GCD_TEST    = 27'h0000008,
    S_GCD_WAIT    = 27'h0000010,
    S_PW_INIT     = 27'h0000020,
    S_PW_BDIV     = 27'h0000040,
    S_PW_BWAIT    = 27'h0000080,
    S_PW_TEST     = 27'h0000100,
    S_PW_RDIV     = 27'h0000200,
    S_PW_RWAIT    = 27'h0000400,
    S_PW_SQ       = 27'h0000800,
    S_PW_SDIV     = 27'h0001000,
    S_PW_SWAIT    = 27'h0002000,
    S_PW_END      = 27'h0004000,
    S_INV_INIT    = 27'h0008000,
    S_INV_TEST    = 27'h0010000,
    S_INV_WAIT    = 27'h0020000,
    S_INV_STEP    = 27'h0040000,
    S_RSA_MUL_N   = 27'h0080000,
    S_RSA_MUL_PHI = 27'h0100000,
    S_RSA_ECHK    = 27'h0200000,
    S_RSA_GCD_END = 27'h0400000,
    S_RSA_D       = 27'h0800000,
    S_RSA_DWAIT   = 27'h1000000,
    S_K_TEST      = 27'h2000000,
    S_FINISH      = 27'h4000000
  } state_e;

  typedef struct packed {
    logic [2:0] func;
    logic       a_one;
    logic       a_lt2;
    logic       b_zero;
    logic       b_lt2;
    logic       n_zero;
    logic       n_one;
    logic       y_zero;
    logic       y_lsb;
    logic       r_one;
    logic       bi_last;
    logic       e_max;
    logic       phi_one;
    logic       k_end;
    logic       kr_zero;
    logic       div_done;
  } status_t;

  function automatic logic [OPW-1:0] fermat_base(input logic [1:0] idx);
    logic [OPW-1:0] b;
    case (idx)
      2'd0:    b = 32'd2;
      2'd1:    b = 32'd3;
      default: b = 32'd5;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/mntu_div.sv */
// ----------------------------------------------------------------------------
// Modular number theory unit divider
// Radix-2 restoring divider, one quotient bit per cycle, registered results.
// ----------------------------------------------------------------------------
module mntu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mntu_pkg::DW-1:0]   dividend_i,
  input  logic [mntu_pkg::DW-1:0]   divisor_i,
  output logic                      done_o,
  output logic [mntu_pkg::DW-1:0]   quot_o,
  output logic [mntu_pkg::DW-1:0]   rem_o
);

  localparam int unsigned DW = mntu_pkg::DW;
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, quo_q, dvs_q;
  logic [DW:0]   shifted, diff;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/mntu_dp.sv */
// ----------------------------------------------------------------------------
// Modular number theory unit datapath
// Operand, exponent, coefficient and result registers, shared multiplier and
// divider, executing one controller command per cycle.
// ----------------------------------------------------------------------------
module mntu_dp #(
  parameter int unsigned WIDTH = mntu_pkg::WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mntu_pkg::cmd_e       cmd_i,
  input  mntu_pkg::req_t       req_i,
  output mntu_pkg::status_t    status_o,
  output mntu_pkg::rsp_t       rsp_o
);

  localparam int unsigned OPW    = mntu_pkg::OPW;
  localparam int unsigned DW     = mntu_pkg::DW;
  localparam int unsigned EW     = mntu_pkg::EW;
  localparam int unsigned COEF_W = mntu_pkg::COEF_W;
  localparam int unsigned MW     = OPW + COEF_W;
  localparam logic [OPW-1:0] OP_MASK = OPW'((64'd1 << WIDTH) - 64'd1);

  logic [2:0]               func_q;
  logic [DW-1:0]            a_q, b_q, prod_q, phi_q, qe_q, kq_q, val_q, pd_q;
  logic [OPW-1:0]           n_q, y_q, r_q, base_q;
  logic signed [COEF_W-1:0] so_q, s_q;
  logic                     qs_neg_q, found_q, err_q;
  logic [1:0]               bi_q;
  logic [EW-1:0]            e_q, re_q, k_q, kr_q, kd_q, pe_q;
  mntu_pkg::rsp_t           out_q;

  logic [DW-1:0]            div_dvd, div_dvs, div_quot, div_rem;
  logic                     div_start, div_done;
  logic [OPW-1:0]           mul_x;
  logic [COEF_W-1:0]        mul_y, s_mag, inv_m;
  logic [MW-1:0]            mul_p;
  logic signed [COEF_W-1:0] qs_term;
  logic [OPW-1:0]           inv_val;
  logic [EW:0]              k_sum, k_res;
  logic                     k_wrap;

  mntu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    div_start = 1'b1;
    case (cmd_i)
      mntu_pkg::CMD_DIV_AB: begin
        div_dvd = a_q;
        div_dvs = b_q;
      end
      mntu_pkg::CMD_DIV_BASE: begin
        div_dvd = DW'(base_q);
        div_dvs = DW'(n_q);
      end
      mntu_pkg::CMD_DIV_PROD: begin
        div_dvd = prod_q;
        div_dvs = DW'(n_q);
      end
      mntu_pkg::CMD_DIV_PHI: begin
        div_dvd = phi_q;
        div_dvs = DW'(e_q);
      end
      default: begin
        div_start = 1'b0;
        div_dvd   = a_q;
        div_dvs   = b_q;
      end
    endcase
  end

  always_comb begin
    s_mag = s_q[COEF_W-1] ? COEF_W'(-s_q) : COEF_W'(s_q);
    case (cmd_i)
      mntu_pkg::CMD_MUL_BB: begin
        mul_x = base_q;
        mul_y = COEF_W'(base_q);
      end
      mntu_pkg::CMD_MUL_QS: begin
        mul_x = div_quot[OPW-1:0];
        mul_y = s_mag;
      end
      mntu_pkg::CMD_RSA_MUL_N: begin
        mul_x = a_q[OPW-1:0];
        mul_y = COEF_W'(b_q[OPW-1:0]);
      end
      mntu_pkg::CMD_RSA_MUL_PHI: begin
        mul_x = a_q[OPW-1:0] - OPW'(1);
        mul_y = COEF_W'(b_q[OPW-1:0] - OPW'(1));
      end
      default: begin
        mul_x = r_q;
        mul_y = COEF_W'(base_q);
      end
    endcase
    mul_p = {{COEF_W{1'b0}}, mul_x} * {{OPW{1'b0}}, mul_y};
  end

  always_comb begin
    qs_term = qs_neg_q ? -$signed(prod_q[COEF_W-1:0]) : $signed(prod_q[COEF_W-1:0]);
    inv_m   = COEF_W'(so_q) + (so_q[COEF_W-1] ? COEF_W'(n_q) : '0);
    inv_val = (inv_m == COEF_W'(n_q)) ? '0 : inv_m[OPW-1:0];
    if (cmd_i == mntu_pkg::CMD_K_INIT) begin
      k_sum = {1'b0, div_rem[EW-1:0]} + (EW+1)'(1);
    end else begin
      k_sum = {1'b0, kr_q} + {1'b0, re_q};
    end
    k_wrap = k_sum >= {1'b0, e_q};
    k_res  = k_wrap ? k_sum - {1'b0, e_q} : k_sum;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      mntu_pkg::CMD_LOAD: begin
        func_q  <= req_i.func;
        a_q     <= DW'(req_i.operand_a & OP_MASK);
        b_q     <= DW'(req_i.operand_b & OP_MASK);
        n_q     <= req_i.modulus_in & OP_MASK;
        bi_q    <= '0;
        val_q   <= '0;
        pe_q    <= '0;
        pd_q    <= '0;
        found_q <= 1'b0;
        err_q   <= 1'b0;
      end
      mntu_pkg::CMD_ERR:      err_q   <= 1'b1;
      mntu_pkg::CMD_SET_ONE:  val_q   <= DW'(1);
      mntu_pkg::CMD_FOUND:    found_q <= 1'b1;
      mntu_pkg::CMD_GCD_STEP: begin
        a_q <= b_q;
        b_q <= div_rem;
      end
      mntu_pkg::CMD_GCD_DONE: val_q <= a_q;
      mntu_pkg::CMD_PW_INIT: begin
        r_q <= (n_q == OPW'(1)) ? '0 : OPW'(1);
        if (func_q == mntu_pkg::FUNC_POW) begin
          base_q <= a_q[OPW-1:0];
          y_q    <= b_q[OPW-1:0];
        end else begin
          base_q <= mntu_pkg::fermat_base(bi_q);
          y_q    <= n_q - OPW'(1);
        end
      end
      mntu_pkg::CMD_SET_BASE: base_q <= div_rem[OPW-1:0];
      mntu_pkg::CMD_SET_BASE_SHIFT: begin
        base_q <= div_rem[OPW-1:0];
        y_q    <= y_q >> 1;
      end
      mntu_pkg::CMD_SET_R:   r_q    <= div_rem[OPW-1:0];
      mntu_pkg::CMD_MUL_RB:  prod_q <= mul_p[DW-1:0];
      mntu_pkg::CMD_MUL_BB:  prod_q <= mul_p[DW-1:0];
      mntu_pkg::CMD_PW_DONE: val_q  <= DW'(r_q);
      mntu_pkg::CMD_BI_INC:  bi_q   <= bi_q + 2'd1;
      mntu_pkg::CMD_INV_INIT: begin
        b_q  <= DW'(n_q);
        so_q <= COEF_W'(1);
        s_q  <= '0;
      end
      mntu_pkg::CMD_MUL_QS: begin
        prod_q   <= mul_p[DW-1:0];
        qs_neg_q <= s_q[COEF_W-1];
      end
      mntu_pkg::CMD_INV_STEP: begin
        a_q  <= b_q;
        b_q  <= div_rem;
        so_q <= s_q;
        s_q  <= so_q - qs_term;
      end
      mntu_pkg::CMD_INV_DONE: begin
        if (a_q == DW'(1)) begin
          found_q <= 1'b1;
          val_q   <= DW'(inv_val);
        end
      end
      mntu_pkg::CMD_RSA_MUL_N: begin
        val_q <= mul_p[DW-1:0];
        e_q   <= mntu_pkg::E_FIRST;
      end
      mntu_pkg::CMD_RSA_MUL_PHI: phi_q <= mul_p[DW-1:0];
      mntu_pkg::CMD_RSA_GCD_INIT: begin
        a_q <= DW'(e_q);
        b_q <= phi_q;
      end
      mntu_pkg::CMD_E_INC: e_q <= e_q + EW'(1);
      mntu_pkg::CMD_K_INIT: begin
        qe_q <= div_quot;
        kq_q <= div_quot;
        re_q <= div_rem[EW-1:0];
        k_q  <= EW'(1);
        kr_q <= k_res[EW-1:0];
        kd_q <= k_wrap ? EW'(1) : '0;
      end
      mntu_pkg::CMD_K_STEP: begin
        k_q  <= k_q + EW'(1);
        kq_q <= kq_q + qe_q;
        kr_q <= k_res[EW-1:0];
        kd_q <= kd_q + (k_wrap ? EW'(1) : '0);
      end
      mntu_pkg::CMD_K_HIT: begin
        pd_q <= kq_q + DW'(kd_q);
        pe_q <= e_q;
      end
      mntu_pkg::CMD_RSA_DONE: pe_q <= e_q;
      mntu_pkg::CMD_PUBLISH: begin
        out_q.value       <= val_q;
        out_q.public_exp  <= pe_q;
        out_q.private_exp <= pd_q;
        out_q.found       <= found_q;
        out_q.error       <= err_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.func     = func_q;
    status_o.a_one    = a_q == DW'(1);
    status_o.a_lt2    = a_q < DW'(2);
    status_o.b_zero   = b_q == '0;
    status_o.b_lt2    = b_q < DW'(2);
    status_o.n_zero   = n_q == '0;
    status_o.n_one    = n_q == OPW'(1);
    status_o.y_zero   = y_q == '0;
    status_o.y_lsb    = y_q[0];
    status_o.r_one    = r_q == OPW'(1);
    status_o.bi_last  = bi_q == mntu_pkg::BASE_LAST;
    status_o.e_max    = e_q == mntu_pkg::E_LIMIT;
    status_o.phi_one  = phi_q == DW'(1);
    status_o.k_end    = k_q == e_q;
    status_o.kr_zero  = kr_q == '0;
    status_o.div_done = div_done;
  end

  assign rsp_o = out_q;

endmodule

/* rtl/core/mntu_ctrl.sv */
// ----------------------------------------------------------------------------
// Modular number theory unit controller
// One-hot sequencer issuing datapath commands and owning both handshakes.
// ----------------------------------------------------------------------------
`include "modular_number_theory_unit_defines.svh"

module mntu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mntu_pkg::status_t status_i,
  output mntu_pkg::cmd_e    cmd_o
);

  mntu_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = mntu_pkg::CMD_NONE;
    case (state_q)
      mntu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = mntu_pkg::CMD_LOAD;
          state_d = mntu_pkg::S_DISPATCH;
        end
      end
      mntu_pkg::S_DISPATCH: begin
        case (status_i.func)
          mntu_pkg::FUNC_GCD: state_d = mntu_pkg::S_GCD_TEST;
          mntu_pkg::FUNC_POW: begin
            if (status_i.b_zero) begin
              cmd_o   = mntu_pkg::CMD_SET_ONE;
              state_d = mntu_pkg::S_FINISH;
            end else if (status_i.n_zero) begin
              state_d = mntu_pkg::S_ERR;
            end else begin
              state_d = mntu_pkg::S_PW_INIT;
            end
          end
          mntu_pkg::FUNC_INV: begin
            state_d = status_i.n_zero ? mntu_pkg::S_ERR : mntu_pkg::S_INV_INIT;
          end
          mntu_pkg::FUNC_PRIME: begin
            if (status_i.n_zero) begin
              state_d = mntu_pkg::S_ERR;
            end else if (status_i.n_one) begin
              cmd_o   = mntu_pkg::CMD_FOUND;
              state_d = mntu_pkg::S_FINISH;
            end else begin
              state_d = mntu_pkg::S_PW_INIT;
            end
          end
          mntu_pkg::FUNC_RSA: begin
            state_d = (status_i.a_lt2 || status_i.b_lt2) ? mntu_pkg::S_ERR
                                                         : mntu_pkg::S_RSA_MUL_N;
          end
          default: state_d = mntu_pkg::S_ERR;
        endcase
      end
      mntu_pkg::S_ERR: begin
        cmd_o   = mntu_pkg::CMD_ERR;
        state_d = mntu_pkg::S_FINISH;
      end
      mntu_pkg::S_GCD_TEST: begin
        if (status_i.b_zero) begin
          if (status_i.func == mntu_pkg::FUNC_RSA) begin
            state_d = mntu_pkg::S_RSA_GCD_END;
          end else begin
            cmd_o   = mntu_pkg::CMD_GCD_DONE;
            state_d = mntu_pkg::S_FINISH;
          end
        end else begin
          cmd_o   = mntu_pkg::CMD_DIV_AB;
          state_d = mntu_pkg::S_GCD_WAIT;
        end
      end
      mntu_pkg::S_GCD_WAIT: begin
        if (status_i.div_done) begin
          cmd_o   = mntu_pkg::CMD_GCD_STEP;
          state_d = mntu_pkg::S_GCD_TEST;
        end
      end
      mntu_pkg::S_PW_INIT: begin
        cmd_o   = mntu_pkg::CMD_PW_INIT;
        state_d = mntu_pkg::S_PW_BDIV;
      end
      mntu_pkg::S_PW_BDIV: begin
        cmd_o   = mntu_pkg::CMD_DIV_BASE;
        state_d = mntu_pkg::S_PW_BWAIT;
      end
      mntu_pkg::S_PW_BWAIT: begin
        if (status_i.div_done) begin
          cmd_o   = mntu_pkg::CMD_SET_BASE;
          state_d = mntu_pkg::S_PW_TEST;
        end
      end
      mntu_pkg::S_PW_TEST: begin
        if (status_i.y_zero) begin
          state_d = mntu_pkg::S_PW_END;
        end else if (status_i.y_lsb) begin
          cmd_o   = mntu_pkg::CMD_MUL_RB;
          state_d = mntu_pkg::S_PW_RDIV;
        end else begin
          state_d = mntu_pkg::S_PW_SQ;
        end
      end
      mntu_pkg::S_PW_RDIV: begin
        cmd_o   = mntu_pkg::CMD_DIV_PROD;
        state_d = mntu_pkg::S_PW_RWAIT;
      end
      mntu_pkg::S_PW_RWAIT: begin
        if (status_i.div_done) begin
          cmd_o   = mntu_pkg::CMD_SET_R;
          state_d = mntu_pkg::S_PW_SQ;
        end
      end
      mntu_pkg::S_PW_SQ: begin
        cmd_o   = mntu_pkg::CMD_MUL_BB;
        state_d = mntu_pkg::S_PW_SDIV;
      end
      mntu_pkg::S_PW_SDIV: begin
        cmd_o   = mntu_pkg::CMD_DIV_PROD;
        state_d = mntu_pkg::S_PW_SWAIT;
      end
      mntu_pkg::S_PW_SWAIT: begin
        if (status_i.div_done) begin
          cmd_o   = mntu_pkg::CMD_SET_BASE_SHIFT;
          state_d = mntu_pkg::S_PW_TEST;
        end
      end
      mntu_pkg::S_PW_END: begin
        state_d = mntu_pkg::S_FINISH;
        if (status_i.func == mntu_pkg::FUNC_POW) begin
          cmd_o = mntu_pkg::CMD_PW_DONE;
        end else if (status_i.r_one) begin
          if (status_i.bi_last) begin
            cmd_o = mntu_pkg::CMD_FOUND;
          end else begin
            cmd_o   = mntu_pkg::CMD_BI_INC;
            state_d = mntu_pkg::S_PW_INIT;
          end
        end
      end
      mntu_pkg::S_INV_INIT: begin
        cmd_o   = mntu_pkg::CMD_INV_INIT;
        state_d = mntu_pkg::S_INV_TEST;
      end
      mntu_pkg::S_INV_TEST: begin
        if (status_i.b_zero) begin
          cmd_o   = mntu_pkg::CMD_INV_DONE;
          state_d = mntu_pkg::S_FINISH;
        end else begin
          cmd_o   = mntu_pkg::CMD_DIV_AB;
          state_d = mntu_pkg::S_INV_WAIT;
        end
      end
      mntu_pkg::S_INV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o   = mntu_pkg::CMD_MUL_QS;
          state_d = mntu_pkg::S_INV_STEP;
        end
      end
      mntu_pkg::S_INV_STEP: begin
        cmd_o   = mntu_pkg::CMD_INV_STEP;
        state_d = mntu_pkg::S_INV_TEST;
      end
      mntu_pkg::S_RSA_MUL_N: begin
        cmd_o   = mntu_pkg::CMD_RSA_MUL_N;
        state_d = mntu_pkg::S_RSA_MUL_PHI;
      end
      mntu_pkg::S_RSA_MUL_PHI: begin
        cmd_o   = mntu_pkg::CMD_RSA_MUL_PHI;
        state_d = mntu_pkg::S_RSA_ECHK;
      end
      mntu_pkg::S_RSA_ECHK: begin
        if (status_i.e_max) begin
          state_d = mntu_pkg::S_RSA_D;
        end else begin
          cmd_o   = mntu_pkg::CMD_RSA_GCD_INIT;
          state_d = mntu_pkg::S_GCD_TEST;
        end
      end
      mntu_pkg::S_RSA_GCD_END: begin
        if (status_i.a_one) begin
          state_d = mntu_pkg::S_RSA_D;
        end else begin
          cmd_o   = mntu_pkg::CMD_E_INC;
          state_d = mntu_pkg::S_RSA_ECHK;
        end
      end
      mntu_pkg::S_RSA_D: begin
        if (status_i.phi_one) begin
          cmd_o   = mntu_pkg::CMD_RSA_DONE;
          state_d = mntu_pkg::S_FINISH;
        end else begin
          cmd_o   = mntu_pkg::CMD_DIV_PHI;
          state_d = mntu_pkg::S_RSA_DWAIT;
        end
      end
      mntu_pkg::S_RSA_DWAIT: begin
        if (status_i.div_done) begin
          cmd_o   = mntu_pkg::CMD_K_INIT;
          state_d = mntu_pkg::S_K_TEST;
        end
      end
      mntu_pkg::S_K_TEST: begin
        if (status_i.k_end) begin
          cmd_o   = mntu_pkg::CMD_RSA_DONE;
          state_d = mntu_pkg::S_FINISH;
        end else if (status_i.kr_zero) begin
          cmd_o   = mntu_pkg::CMD_K_HIT;
          state_d = mntu_pkg::S_FINISH;
        end else begin
          cmd_o = mntu_pkg::CMD_K_STEP;
        end
      end
      mntu_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o   = mntu_pkg::CMD_PUBLISH;
          state_d = mntu_pkg::S_IDLE;
        end
      end
      default: state_d = mntu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o == mntu_pkg::CMD_PUBLISH) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mntu_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == mntu_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;

  `MNTU_ASSERT_NEXT(a_accept_dispatch, in_valid_i && in_ready_o, state_q == mntu_pkg::S_DISPATCH, "accepted transaction did not dispatch")
  `MNTU_ASSERT_NEXT(a_publish_valid, cmd_o == mntu_pkg::CMD_PUBLISH, out_valid_o, "published result not presented")
  `MNTU_ASSERT_NEXT(a_gcd_wait_hold, (state_q == mntu_pkg::S_GCD_WAIT) && !status_i.div_done, state_q == mntu_pkg::S_GCD_WAIT, "left division wait early")

endmodule

/* rtl/core/modular_number_theory_unit.sv */
// Gcd runs one division per Euclid step; modular power runs up to two divisions
// per exponent bit; the Fermat test runs up to three such powers; RSA key
// generation adds the gcd search for e and a stepwise search for d. All
// divisions use the shared radix-2 divider. One transaction at a time; a result
// may wait in the output register while the next transaction is accepted.
// Reset clears all control.
// ----------------------------------------------------------------------------
// Modular number theory unit
// Gcd, modular power, modular inverse, Fermat test and RSA key generation.
// ----------------------------------------------------------------------------
module modular_number_theory_unit #(
  parameter int unsigned WIDTH = mntu_pkg::WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mntu_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mntu_pkg::rsp_t out_data_o
);

  mntu_pkg::cmd_e    cmd;
  mntu_pkg::status_t status;

  mntu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mntu_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (in_data_i),
    .status_o (status),
    .rsp_o    (out_data_o)
  );

endmodule
